/* sv/nroot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nroot_pkg
// Types and fixed constants shared by the integer n-th root block and its
// checker.
// ----------------------------------------------------------------------------
package nroot_pkg;

    localparam int RADICAND_W = 64;
    localparam int DEGREE_W   = 7;
    localparam int HALF_W     = 32;
    localparam int BIT_IDX_W  = 5;
    localparam int COUNT_W    = 6;

    typedef struct packed {
        logic [RADICAND_W-1:0] radicand;
        logic [DEGREE_W-1:0]   degree;
    } nroot_in_t;

    typedef struct packed {
        logic [RADICAND_W-1:0] root;
        logic                  invalid;
    } nroot_out_t;

endpackage

/* sv/integer_nth_root.sv */
`timescale 1ns / 1ps
// A word with degree 0, degree 1, degree of DATA_WIDTH or more, or a zero radicand
// goes from acceptance through ST_SETUP to ST_DONE. Otherwise the bit-serial search
// runs at most 32 x degree multiplications on the one shared 32 x 32 multiplier,
// each through ST_MUL_LO, ST_MUL_HI and ST_CHECK; a bit trial stops at the first
// product that exceeds the radicand. s_ready returns with m_valid, so a new word is
// taken only once the last result is issued. Reset clears the sequencer and m_valid.
// ----------------------------------------------------------------------------
// integer_nth_root
// Floor of the degree-th root of an unsigned radicand, found one result bit
// at a time by raising each candidate to the degree on a shared multiplier.
// ----------------------------------------------------------------------------
module integer_nth_root
    import nroot_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  nroot_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output nroot_out_t m_data
);

    localparam logic [RADICAND_W-1:0] RAD_MASK  =
        {RADICAND_W{1'b1}} >> (RADICAND_W - DATA_WIDTH);
    localparam logic [DEGREE_W-1:0]   DEG_LIMIT = DEGREE_W'(DATA_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t                  state_reg,   state_next;
    logic [RADICAND_W-1:0]   n_reg,       n_next;
    logic [DEGREE_W-1:0]     deg_reg,     deg_next;
    logic [RADICAND_W-1:0]   root_reg,    root_next;
    logic                    inv_reg,     inv_next;
    logic [BIT_IDX_W-1:0]    bit_reg,     bit_next;
    logic [COUNT_W-1:0]      k_reg,       k_next;
    logic [RADICAND_W-1:0]   acc_reg,     acc_next;
    logic [2*HALF_W-1:0]     p_lo_reg,    p_lo_next;
    logic [2*HALF_W-1:0]     p_hi_reg,    p_hi_next;
    logic                    m_valid_reg, m_valid_next;
    nroot_out_t              m_data_reg,  m_data_next;

    logic [HALF_W-1:0]       cand;
    logic [HALF_W-1:0]       mul_a;
    logic [2*HALF_W-1:0]     mul_p;
    logic [3*HALF_W-1:0]     prod;
    logic                    too_big;
    logic                    last_mul;

    // Candidate is the root so far with the current trial bit set.
    assign cand  = root_reg[HALF_W-1:0] | (HALF_W'(1) << bit_reg);
    assign mul_a = (state_reg == ST_MUL_HI) ? acc_reg[RADICAND_W-1:HALF_W]
                                            : acc_reg[HALF_W-1:0];
    assign mul_p = (2*HALF_W)'(mul_a) * (2*HALF_W)'(cand);

    // Full 96-bit product of the running power and the candidate.
    assign prod     = {p_hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, p_lo_reg};
    assign too_big  = prod > {{HALF_W{1'b0}}, n_reg};
    assign last_mul = ({1'b0, k_reg} + DEGREE_W'(1)) == deg_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        deg_next     = deg_reg;
        root_next    = root_reg;
        inv_next     = inv_reg;
        bit_next     = bit_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        p_lo_next    = p_lo_reg;
        p_hi_next    = p_hi_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next     = s_data.radicand & RAD_MASK;
                    deg_next   = s_data.degree;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                inv_next   = 1'b0;
                root_next  = '0;
                bit_next   = '1;
                k_next     = '0;
                acc_next   = RADICAND_W'(1);
                state_next = ST_DONE;
                if (deg_reg == '0) begin
                    root_next = RADICAND_W'(1);
                    inv_next  = (n_reg == '0);
                end else if (deg_reg == DEGREE_W'(1)) begin
                    root_next = n_reg;
                end else if (deg_reg >= DEG_LIMIT) begin
                    root_next = RADICAND_W'(n_reg != '0);
                end else if (n_reg != '0) begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                p_lo_next  = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                p_hi_next  = mul_p;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!too_big && !last_mul) begin
                    acc_next   = prod[RADICAND_W-1:0];
                    k_next     = k_reg + COUNT_W'(1);
                    state_next = ST_MUL_LO;
                end else begin
                    // Trial for this bit is settled; keep the bit if the power fits.
                    if (!too_big) begin
                        root_next = {{HALF_W{1'b0}}, cand};
                    end
                    acc_next = RADICAND_W'(1);
                    k_next   = '0;
                    if (bit_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        bit_next   = bit_reg - BIT_IDX_W'(1);
                        state_next = ST_MUL_LO;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.root    = root_reg;
                    m_data_next.invalid = inv_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        deg_reg    <= deg_next;
        root_reg   <= root_next;
        inv_reg    <= inv_next;
        bit_reg    <= bit_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        p_lo_reg   <= p_lo_next;
        p_hi_reg   <= p_hi_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* sv/nroot_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nroot_checker
// Port-level checks on the integer n-th root block, bound to its top level.
// ----------------------------------------------------------------------------
module nroot_checker
    import nroot_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input nroot_out_t m_data
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in progress");

    // Only degree zero with a zero radicand is flagged invalid, and its root is always one.
    a_invalid_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.invalid |-> m_data.root == 64'd1)
        else $error("invalid result with a root other than one");

    // Reset leaves no result word pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind integer_nth_root nroot_checker u_nroot_checker (.*);
